// File: rtl/huffman_stream_decoder_assert.svh
// Assertion macros used by the decoder controller (hsd_ctrl).
// Expects i_clk and i_rst_n in the including module.
`ifndef HUFFMAN_STREAM_DECODER_ASSERT_SVH
`define HUFFMAN_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define HSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hsd_pkg.sv
// Package for the Huffman stream decoder: sizes, codes, enums and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package hsd_pkg;

    localparam int NODE_COUNT         = 512;
    localparam int NODE_AW            = $clog2(NODE_COUNT);
    localparam int NODE_CW            = NODE_AW + 1;
    localparam int MAX_PASSWORD_BYTES = 8;

    localparam logic CFG_PWD_WORD = 1'b0;
    localparam logic CFG_PWD_LEN  = 1'b1;

    typedef enum logic [2:0] {
        PH_SIZE, PH_ALPHA, PH_PWLEN, PH_PWD, PH_TSYM, PH_TLEN, PH_TPATH, PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        RS_SYMBOL, RS_PASSWORD, RS_OVERFLOW, RS_INVALID
    } t_status;

    typedef enum logic [2:0] {
        CS_CLEAR, CS_IDLE, CS_BIT, CS_WAIT, CS_FLUSH
    } t_ctrl_state;

    typedef struct packed {
        logic clr;        // clear one node row
        logic accept;     // take the input byte
        logic step;       // consume one stream bit
        logic wait_step;  // use node read data
        logic flush;      // release pending result as last
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic start_in;
        logic go_bits;
        logic out_free;
        logic rd_issue;
        logic stop;
        logic bit_last;
        logic bits_empty;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: rtl/hsd_if.sv
// Channel interfaces of the Huffman stream decoder: byte input, result
// output and configuration write. No dependencies.
`default_nettype none
interface hsd_byte_if;
    logic       valid;
    logic       ready;
    logic       start_file;
    logic [7:0] data_byte;
    modport source (output valid, output start_file, output data_byte, input ready);
    modport sink   (input valid, input start_file, input data_byte, output ready);
endinterface

interface hsd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic [1:0] status;
    logic       end_of_file;
    logic       last;
    modport source (output valid, output symbol, output status, output end_of_file,
                    output last, input ready);
    modport sink   (input valid, input symbol, input status, input end_of_file,
                    input last, output ready);
endinterface

interface hsd_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/hsd_ctrl.sv
// Sequencing FSM of the Huffman stream decoder.
// Depends on hsd_pkg and huffman_stream_decoder_assert.svh.
`default_nettype none
`include "huffman_stream_decoder_assert.svh"
module hsd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  hsd_pkg::t_dp_sts i_sts,
    output hsd_pkg::t_dp_cmd o_cmd
);
    import hsd_pkg::*;

    t_ctrl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            CS_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = CS_IDLE;
                end
            end
            CS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.start_in) begin
                        n_state = CS_CLEAR;
                    end else if (i_sts.go_bits) begin
                        n_state = CS_BIT;
                    end else begin
                        n_state = CS_FLUSH;
                    end
                end
            end
            CS_BIT: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.rd_issue) begin
                        n_state = CS_WAIT;
                    end else if (i_sts.stop || i_sts.bit_last) begin
                        n_state = CS_FLUSH;
                    end
                end
            end
            CS_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.wait_step = 1'b1;
                    n_state = i_sts.bits_empty ? CS_FLUSH : CS_BIT;
                end
            end
            CS_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    `HSD_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(o_cmd), "more than one datapath command")
    `HSD_ASSERT_NXT(a_start_clears, (o_cmd.accept && i_sts.start_in), (r_state == CS_CLEAR), "start did not clear")
    `HSD_ASSERT_NXT(a_read_waits, (o_cmd.step && i_sts.rd_issue), (r_state == CS_WAIT), "node read not awaited")

endmodule
`default_nettype wire

// File: rtl/hsd_dp.sv
// Datapath of the Huffman stream decoder: header parse, node memories,
// tree walk, pending result and output register. Depends on hsd_pkg.
`default_nettype none
module hsd_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hsd_pkg::t_dp_cmd i_cmd,
    output hsd_pkg::t_dp_sts o_sts,
    input  logic             i_in_start,
    input  logic [7:0]       i_in_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_out_symbol,
    output logic [1:0]       o_out_status,
    output logic             o_out_eof,
    output logic             o_out_last,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [63:0]      i_cfg_data
);
    import hsd_pkg::*;

    localparam int RW = 2 * NODE_AW;

    // parse state
    t_phase              r_phase, n_phase;
    logic [7:0]          r_hcnt, n_hcnt;
    logic [63:0]         r_remain, n_remain;
    logic [7:0]          r_pwlen, n_pwlen;
    logic                r_mism, n_mism;
    logic [8:0]          r_entries, n_entries;
    logic [7:0]          r_buf, n_buf;
    logic [3:0]          r_bits, n_bits;
    logic [8:0]          r_plen, n_plen;
    logic [7:0]          r_esym, n_esym;
    logic [NODE_CW-1:0]  r_used, n_used;
    logic [NODE_AW-1:0]  r_cur, n_cur;
    logic [NODE_AW-1:0]  r_cur_l, n_cur_l, r_cur_r, n_cur_r;
    logic [NODE_AW-1:0]  r_root_l, n_root_l, r_root_r, n_root_r;
    logic                r_err, n_err;
    logic [NODE_AW-1:0]  r_clr, n_clr;
    // configuration
    logic [63:0]         r_pw_word;
    logic [3:0]          r_pw_len;
    // pending and output results
    logic                r_p_valid, n_p_valid;
    logic [7:0]          r_p_sym, n_p_sym;
    t_status             r_p_st, n_p_st;
    logic                r_p_eof, n_p_eof;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_sym, n_out_sym;
    t_status             r_out_st, n_out_st;
    logic                r_out_eof, n_out_eof;
    logic                r_out_last, n_out_last;
    // node memories
    logic [RW-1:0]       r_child_mem [NODE_COUNT];
    logic [7:0]          r_sym_mem [NODE_COUNT];
    logic [RW-1:0]       r_rd_row;
    logic [7:0]          r_rd_sym;

    logic                cw_en, sw_en, rd_en;
    logic [NODE_AW-1:0]  cw_addr, sw_addr, rd_addr;
    logic [RW-1:0]       cw_data;
    logic                push;
    logic [7:0]          push_sym;
    t_status             push_st;
    logic                push_eof;
    logic                bit_b, path_end;
    logic [NODE_AW-1:0]  nxt, new_node, upd_l, upd_r;
    logic [7:0]          shifted;
    logic [3:0]          cfg_len;
    logic                mism;

    always_comb begin
        n_phase = r_phase;   n_hcnt = r_hcnt;     n_remain = r_remain;
        n_pwlen = r_pwlen;   n_mism = r_mism;     n_entries = r_entries;
        n_buf = r_buf;       n_bits = r_bits;     n_plen = r_plen;
        n_esym = r_esym;     n_used = r_used;     n_cur = r_cur;
        n_cur_l = r_cur_l;   n_cur_r = r_cur_r;   n_root_l = r_root_l;
        n_root_r = r_root_r; n_err = r_err;       n_clr = r_clr;
        n_p_valid = r_p_valid; n_p_sym = r_p_sym; n_p_st = r_p_st; n_p_eof = r_p_eof;
        n_out_sym = r_out_sym; n_out_st = r_out_st; n_out_eof = r_out_eof;
        n_out_last = r_out_last;
        n_out_valid = r_out_valid && !i_out_ready;
        cw_en = 1'b0; cw_addr = r_cur; cw_data = '0;
        sw_en = 1'b0; sw_addr = r_cur;
        rd_en = 1'b0; rd_addr = r_cur;
        push = 1'b0; push_sym = 8'd0; push_st = RS_SYMBOL; push_eof = 1'b0;
        bit_b = r_buf[7];
        nxt = bit_b ? r_cur_r : r_cur_l;
        new_node = r_used[NODE_AW-1:0];
        upd_l = r_cur_l;
        upd_r = r_cur_r;
        path_end = (r_plen == 9'd1);
        shifted = {r_plen[6:0], bit_b};
        cfg_len = (r_pw_len > 4'(MAX_PASSWORD_BYTES)) ? 4'(MAX_PASSWORD_BYTES) : r_pw_len;
        mism = r_mism;
        o_sts = '0;

        if (i_cmd.clr) begin
            cw_en = 1'b1;
            cw_addr = r_clr;
            n_clr = r_clr + NODE_AW'(1);
        end

        if (i_cmd.accept) begin
            if (i_in_start) begin
                n_phase = PH_SIZE;   n_hcnt = 8'd1;  n_remain = {56'd0, i_in_data};
                n_pwlen = 8'd0;      n_mism = 1'b0;  n_entries = 9'd0;
                n_buf = 8'd0;        n_bits = 4'd0;  n_plen = 9'd0;
                n_esym = 8'd0;       n_used = NODE_CW'(1);
                n_cur = '0; n_cur_l = '0; n_cur_r = '0; n_root_l = '0; n_root_r = '0;
                n_err = 1'b0;
            end else if (!r_err) begin
                case (r_phase)
                    PH_SIZE: begin
                        for (int k = 0; k < 8; k++) begin
                            if (r_hcnt[2:0] == 3'(k)) begin
                                n_remain[k*8 +: 8] = r_remain[k*8 +: 8] | i_in_data;
                            end
                        end
                        n_hcnt = r_hcnt + 8'd1;
                        if (r_hcnt == 8'd7) begin
                            n_hcnt = 8'd0;
                            n_phase = PH_ALPHA;
                        end
                    end
                    PH_ALPHA: begin
                        n_entries = (i_in_data == 8'd0) ? 9'd256 : {1'b0, i_in_data};
                        n_phase = PH_PWLEN;
                    end
                    PH_PWLEN: begin
                        n_pwlen = i_in_data;
                        n_hcnt = 8'd0;
                        n_mism = 1'b0;
                        n_esym = 8'd0;
                        n_phase = (i_in_data != 8'd0) ? PH_PWD : PH_TSYM;
                    end
                    PH_PWD: begin
                        if (r_hcnt < 8'(MAX_PASSWORD_BYTES)) begin
                            if (r_pw_word[r_hcnt[2:0]*8 +: 8] != i_in_data) begin
                                mism = 1'b1;
                            end
                        end else begin
                            mism = 1'b1;
                        end
                        n_hcnt = r_hcnt + 8'd1;
                        if (({1'b0, r_hcnt} + 9'd1) >= {1'b0, r_pwlen}) begin
                            if ({4'd0, cfg_len} != r_pwlen) begin
                                mism = 1'b1;
                            end
                            n_hcnt = 8'd0;
                            n_esym = 8'd0;
                            if (mism) begin
                                push = 1'b1;
                                push_st = RS_PASSWORD;
                                n_err = 1'b1;
                            end else begin
                                n_phase = PH_TSYM;
                            end
                        end
                        n_mism = mism;
                    end
                    default: begin
                        n_buf = i_in_data;
                        n_bits = 4'd8;
                    end
                endcase
            end
        end

        if (i_cmd.step) begin
            n_buf = {r_buf[6:0], 1'b0};
            n_bits = r_bits - 4'd1;
            case (r_phase)
                PH_TSYM: begin
                    n_esym = {r_esym[6:0], bit_b};
                    n_hcnt = r_hcnt + 8'd1;
                    if (r_hcnt == 8'd7) begin
                        n_hcnt = 8'd0;
                        n_plen = 9'd0;
                        n_phase = PH_TLEN;
                    end
                end
                PH_TLEN: begin
                    n_plen = {1'b0, shifted};
                    n_hcnt = r_hcnt + 8'd1;
                    if (r_hcnt == 8'd7) begin
                        n_hcnt = 8'd0;
                        if (shifted == 8'd0) begin
                            n_plen = 9'd256;
                        end
                        n_cur = '0;
                        n_cur_l = r_root_l;
                        n_cur_r = r_root_r;
                        n_phase = PH_TPATH;
                    end
                end
                PH_TPATH: begin
                    if (nxt == '0 && r_used == NODE_CW'(NODE_COUNT)) begin
                        push = 1'b1;
                        push_st = RS_OVERFLOW;
                        n_err = 1'b1;
                        o_sts.stop = 1'b1;
                    end else begin
                        if (nxt == '0) begin
                            // grow a fresh node; its row is already clear
                            n_used = r_used + NODE_CW'(1);
                            if (bit_b) begin
                                upd_r = new_node;
                            end else begin
                                upd_l = new_node;
                            end
                            cw_en = 1'b1;
                            cw_addr = r_cur;
                            cw_data = {upd_l, upd_r};
                            if (r_cur == '0) begin
                                n_root_l = upd_l;
                                n_root_r = upd_r;
                            end
                            n_cur = new_node;
                            n_cur_l = '0;
                            n_cur_r = '0;
                        end else if (!path_end) begin
                            rd_en = 1'b1;
                            rd_addr = nxt;
                            n_cur = nxt;
                            o_sts.rd_issue = 1'b1;
                        end
                        n_plen = r_plen - 9'd1;
                        if (path_end) begin
                            sw_en = 1'b1;
                            sw_addr = (nxt == '0) ? new_node : nxt;
                            n_entries = r_entries - 9'd1;
                            n_cur = '0;
                            n_cur_l = n_root_l;
                            n_cur_r = n_root_r;
                            n_hcnt = 8'd0;
                            n_esym = 8'd0;
                            n_phase = (r_entries == 9'd1) ? PH_BODY : PH_TSYM;
                        end
                    end
                end
                PH_BODY: begin
                    if (r_remain != 64'd0) begin
                        if (nxt == '0) begin
                            push = 1'b1;
                            push_st = RS_INVALID;
                            n_err = 1'b1;
                            o_sts.stop = 1'b1;
                        end else begin
                            rd_en = 1'b1;
                            rd_addr = nxt;
                            n_cur = nxt;
                            o_sts.rd_issue = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.wait_step) begin
            if (r_phase == PH_BODY && r_rd_row == '0) begin
                // leaf: emit and restart at the root
                n_remain = r_remain - 64'd1;
                push = 1'b1;
                push_sym = r_rd_sym;
                push_eof = (r_remain == 64'd1);
                n_cur = '0;
                n_cur_l = r_root_l;
                n_cur_r = r_root_r;
            end else begin
                n_cur_l = r_rd_row[RW-1:NODE_AW];
                n_cur_r = r_rd_row[NODE_AW-1:0];
            end
        end

        if (push) begin
            if (r_p_valid) begin
                n_out_valid = 1'b1;
                n_out_sym = r_p_sym; n_out_st = r_p_st; n_out_eof = r_p_eof;
                n_out_last = 1'b0;
            end
            n_p_valid = 1'b1;
            n_p_sym = push_sym; n_p_st = push_st; n_p_eof = push_eof;
        end

        if (i_cmd.flush && r_p_valid) begin
            n_out_valid = 1'b1;
            n_out_sym = r_p_sym; n_out_st = r_p_st; n_out_eof = r_p_eof;
            n_out_last = 1'b1;
            n_p_valid = 1'b0;
        end

        o_sts.clr_done   = (r_clr == '1);
        o_sts.start_in   = i_in_start;
        o_sts.go_bits    = !r_err && (r_phase == PH_TSYM || r_phase == PH_TLEN ||
                                      r_phase == PH_TPATH || r_phase == PH_BODY);
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.bit_last   = (r_bits == 4'd1);
        o_sts.bits_empty = (r_bits == 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;  r_hcnt <= 8'd0;  r_remain <= 64'd0;
            r_pwlen <= 8'd0;     r_mism <= 1'b0;  r_entries <= 9'd0;
            r_buf <= 8'd0;       r_bits <= 4'd0;  r_plen <= 9'd0;
            r_esym <= 8'd0;      r_used <= NODE_CW'(1);
            r_cur <= '0; r_cur_l <= '0; r_cur_r <= '0; r_root_l <= '0; r_root_r <= '0;
            r_err <= 1'b0;       r_clr <= '0;
            r_pw_word <= 64'd0;  r_pw_len <= 4'd0;
            r_p_valid <= 1'b0;   r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;  r_hcnt <= n_hcnt;  r_remain <= n_remain;
            r_pwlen <= n_pwlen;  r_mism <= n_mism;  r_entries <= n_entries;
            r_buf <= n_buf;      r_bits <= n_bits;  r_plen <= n_plen;
            r_esym <= n_esym;    r_used <= n_used;
            r_cur <= n_cur; r_cur_l <= n_cur_l; r_cur_r <= n_cur_r;
            r_root_l <= n_root_l; r_root_r <= n_root_r;
            r_err <= n_err;      r_clr <= n_clr;
            r_p_valid <= n_p_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PWD_WORD: r_pw_word <= i_cfg_data;
                    CFG_PWD_LEN:  r_pw_len <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_sym <= n_p_sym;     r_p_st <= n_p_st;     r_p_eof <= n_p_eof;
        r_out_sym <= n_out_sym; r_out_st <= n_out_st; r_out_eof <= n_out_eof;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (cw_en) begin
            r_child_mem[cw_addr] <= cw_data;
        end
        if (rd_en) begin
            r_rd_row <= r_child_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sw_en) begin
            r_sym_mem[sw_addr] <= r_esym;
        end
        if (rd_en) begin
            r_rd_sym <= r_sym_mem[rd_addr];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_symbol = r_out_sym;
    assign o_out_status = r_out_st;
    assign o_out_eof    = r_out_eof;
    assign o_out_last   = r_out_last;

endmodule
`default_nettype wire

// File: rtl/huffman_stream_decoder.sv
// Top level of the Huffman stream decoder: controller plus datapath.
// Depends on hsd_pkg, hsd_if, hsd_ctrl and hsd_dp.
//
//  channel    dir  payload                                 transfer when
//  i_byte     in   start_file, data_byte                   valid & ready
//  o_result   out  symbol, status, end_of_file, last       valid & ready
//  i_cfg      in   index (0 word, 1 length), data[63:0]    valid & ready (always ready)
//
// Sequence: a header byte is accepted and then flushed; a table or body byte
// takes its bit steps plus a wait state per node-memory read (body bits and
// revisited path nodes), between accept and final flush.
// The child-pointer memory has one port with registered read data; each
// tree step that follows an existing node, but the last step of a table path, issues that read.
// Reset, and every byte with start_file, runs a clearing pass over all
// NODE_COUNT (512) rows of the node memory with i_byte not ready.
// A stalled o_result holds the walk; results wait one deep in a pending
// register until the next result or end of byte fixes their last flag.
`default_nettype none
module huffman_stream_decoder (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hsd_byte_if.sink     i_byte,
    hsd_result_if.source o_result,
    hsd_cfg_if.sink      i_cfg
);
    import hsd_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    hsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_byte.valid),
        .o_in_ready (i_byte.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hsd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_start   (i_byte.start_file),
        .i_in_data    (i_byte.data_byte),
        .i_out_ready  (o_result.ready),
        .o_out_valid  (o_result.valid),
        .o_out_symbol (o_result.symbol),
        .o_out_status (o_result.status),
        .o_out_eof    (o_result.end_of_file),
        .o_out_last   (o_result.last),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data)
    );

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for huffman_stream_decoder: random compressed files in,
// decoded symbols and error results checked against an in-bench predictor.
// Depends on hsd_pkg, hsd_if and the decoder RTL.
`default_nettype none
module tb_top;
    import hsd_pkg::*;

    logic i_clk;
    logic i_rst_n;

    hsd_byte_if   byte_ch();
    hsd_result_if res_ch();
    hsd_cfg_if    cfg_ch();

    huffman_stream_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch.sink),
        .o_result (res_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    // one file byte waiting to be offered
    typedef struct {
        bit         sf;
        logic [7:0] data;
    } file_byte_t;

    // one decoder result
    typedef struct {
        logic [7:0] sym;
        t_status    st;
        logic       eof;
        logic       last;
    } decode_res_t;

    file_byte_t  byte_queue[$];
    decode_res_t expected_res[$];

    int tx_idle_pct = 26;
    int rx_idle_pct = 26;
    int errors      = 0;
    int bytes_fed   = 0;
    int n_symbols   = 0;
    int n_eof       = 0;
    int n_faults    = 0;

    // receiver hold-off, counted in its own process
    bit hold_req  = 0;
    bit hold_seen = 0;
    int hold_cnt  = 0;

    //------------------------------------------------------------------
    // Predictor state: configuration and parse state of the decoder
    //------------------------------------------------------------------
    logic [63:0] pw_word;
    logic [3:0]  pw_len;

    t_phase      ph;
    int unsigned hdr_cnt;
    logic [63:0] syms_left;
    int unsigned stored_pw_len;
    bit          pw_bad;
    int unsigned entries_left;
    int unsigned path_left;
    logic [7:0]  entry_sym;
    logic [9:0]  left_child  [NODE_COUNT];
    logic [9:0]  right_child [NODE_COUNT];
    logic [7:0]  node_sym    [NODE_COUNT];
    int unsigned nodes_used;
    int unsigned cur_node;
    bit          fault_latched;

    // results of the byte being predicted
    decode_res_t byte_res[8];
    int          n_byte_res;

    task automatic clear_parse();
        ph            = PH_SIZE;
        hdr_cnt       = 0;
        syms_left     = '0;
        stored_pw_len = 0;
        pw_bad        = 0;
        entries_left  = 0;
        path_left     = 0;
        entry_sym     = '0;
        for (int i = 0; i < NODE_COUNT; i++) begin
            left_child[i]  = '0;
            right_child[i] = '0;
            node_sym[i]    = '0;
        end
        nodes_used    = 1;
        cur_node      = 0;
        fault_latched = 0;
    endtask

    task automatic add_result(input logic [7:0] sym, input t_status st, input logic eof);
        byte_res[n_byte_res] = '{sym, st, eof, 1'b0};
        n_byte_res++;
    endtask

    // one bit of the table/body stream; ok drops on an error
    task automatic tree_bit(input bit b, output bit ok);
        int unsigned nxt;
        ok = 1;
        case (ph)
            PH_TSYM: begin
                entry_sym = {entry_sym[6:0], b};
                if (++hdr_cnt >= 8) begin
                    hdr_cnt   = 0;
                    path_left = 0;
                    ph        = PH_TLEN;
                end
            end
            PH_TLEN: begin
                path_left = ((path_left << 1) | b) & 8'hFF;
                if (++hdr_cnt >= 8) begin
                    hdr_cnt = 0;
                    if (path_left == 0) path_left = 256;
                    cur_node = 0;
                    ph       = PH_TPATH;
                end
            end
            PH_TPATH: begin
                nxt = b ? right_child[cur_node] : left_child[cur_node];
                if (nxt == 0) begin
                    if (nodes_used >= NODE_COUNT) begin
                        add_result(8'h00, RS_OVERFLOW, 1'b0);
                        fault_latched = 1;
                        ok = 0;
                        return;
                    end
                    nxt = nodes_used++;
                    if (b) right_child[cur_node] = nxt[9:0];
                    else   left_child[cur_node]  = nxt[9:0];
                end
                cur_node = nxt;
                if (--path_left == 0) begin
                    node_sym[nxt] = entry_sym;
                    entries_left--;
                    cur_node  = 0;
                    hdr_cnt   = 0;
                    entry_sym = '0;
                    ph = (entries_left == 0) ? PH_BODY : PH_TSYM;
                end
            end
            PH_BODY: begin
                if (syms_left != 0) begin
                    nxt = b ? right_child[cur_node] : left_child[cur_node];
                    if (nxt == 0) begin
                        add_result(8'h00, RS_INVALID, 1'b0);
                        fault_latched = 1;
                        ok = 0;
                        return;
                    end
                    if (left_child[nxt] == 0 && right_child[nxt] == 0) begin
                        syms_left--;
                        add_result(node_sym[nxt], RS_SYMBOL, syms_left == 0);
                        cur_node = 0;
                    end else begin
                        cur_node = nxt;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // expected results for one accepted file byte
    task automatic predict_byte(input bit sf, input logic [7:0] b);
        int unsigned cfg_len;
        bit          ok;
        int          i;
        n_byte_res = 0;
        if (sf) clear_parse();
        if (fault_latched) return;
        case (ph)
            PH_SIZE: begin
                syms_left[8*(hdr_cnt & 7) +: 8] = b;
                if (++hdr_cnt >= 8) begin
                    hdr_cnt = 0;
                    ph      = PH_ALPHA;
                end
            end
            PH_ALPHA: begin
                entries_left = (b != 0) ? b : 256;
                ph = PH_PWLEN;
            end
            PH_PWLEN: begin
                stored_pw_len = b;
                hdr_cnt   = 0;
                pw_bad    = 0;
                entry_sym = '0;
                ph = (b != 0) ? PH_PWD : PH_TSYM;
            end
            PH_PWD: begin
                if (hdr_cnt < MAX_PASSWORD_BYTES) begin
                    if (pw_word[8*hdr_cnt +: 8] != b) pw_bad = 1;
                end else begin
                    pw_bad = 1;
                end
                if (++hdr_cnt >= stored_pw_len) begin
                    // configured lengths above the maximum count as the maximum
                    cfg_len = (pw_len > MAX_PASSWORD_BYTES) ? MAX_PASSWORD_BYTES : pw_len;
                    if (cfg_len != stored_pw_len) pw_bad = 1;
                    hdr_cnt   = 0;
                    entry_sym = '0;
                    if (pw_bad) begin
                        add_result(8'h00, RS_PASSWORD, 1'b0);
                        fault_latched = 1;
                    end else begin
                        ph = PH_TSYM;
                    end
                end
            end
            default: begin
                // table and body share one MSB-first bit stream
                ok = 1;
                i  = 7;
                while (ok && i >= 0) begin
                    tree_bit(b[i], ok);
                    i--;
                end
            end
        endcase
        for (i = 0; i < n_byte_res; i++) begin
            byte_res[i].last = (i == n_byte_res - 1);
            expected_res.push_back(byte_res[i]);
        end
    endtask

    //------------------------------------------------------------------
    // Clock, reset, deadline
    //------------------------------------------------------------------
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("tb_top: errors");
        $finish;
    end

    //------------------------------------------------------------------
    // Byte driver: offers queued file bytes, predicts on each transfer
    //------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_drv
        file_byte_t nxt_byte;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                predict_byte(byte_ch.start_file, byte_ch.data_byte);
                bytes_fed++;
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt_byte = byte_queue.pop_front();
                    byte_ch.valid      <= 1'b1;
                    byte_ch.start_file <= nxt_byte.sf;
                    byte_ch.data_byte  <= nxt_byte.data;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long hold-off of the result side, triggered once from the sequence
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (hold_req && !hold_seen) begin
            hold_cnt  <= 3000;
            hold_seen <= 1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_cnt != 0)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    //------------------------------------------------------------------
    // Result monitor: each transfer against the oldest expectation
    //------------------------------------------------------------------
    always @(posedge i_clk) begin : res_mon
        decode_res_t want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_res.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: sym %h st %0d eof %b last %b",
                             res_ch.symbol, res_ch.status, res_ch.end_of_file, res_ch.last);
            end else begin
                want = expected_res.pop_front();
                if (res_ch.symbol !== want.sym || res_ch.status !== want.st ||
                    res_ch.end_of_file !== want.eof || res_ch.last !== want.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp sym %h st %0d eof %b last %b,",
                                 want.sym, want.st, want.eof, want.last,
                                 " got sym %h st %0d eof %b last %b", res_ch.symbol,
                                 res_ch.status, res_ch.end_of_file, res_ch.last);
                end
                if (want.st == RS_SYMBOL) n_symbols++; else n_faults++;
                if (want.eof) n_eof++;
            end
        end
    end

    //------------------------------------------------------------------
    // File builder
    //------------------------------------------------------------------
    logic [7:0] bit_acc;
    int         bit_cnt;
    bit         next_sf;

    task automatic push_byte(input logic [7:0] v);
        byte_queue.push_back('{next_sf, v});
        next_sf = 0;
    endtask

    task automatic put_bit(input bit b);
        bit_acc = {bit_acc[6:0], b};
        if (++bit_cnt == 8) begin
            push_byte(bit_acc);
            bit_cnt = 0;
        end
    endtask

    task automatic put_bits8(input logic [7:0] v);
        for (int j = 7; j >= 0; j--) put_bit(v[j]);
    endtask

    // special: 0 plain tree, 1 one 256-bit code, 2 node overflow, 3 256 entries
    // cnt_mode: 0 exact count, 1 zero, 2 ends early, 3 never ends
    task automatic build_file(input bit sf, input int special, input int nleaf,
                              input bit drop, input bit pw_ok, input int cnt_mode);
        logic [255:0] codes[$];
        int           lens[$];
        logic [255:0] c;
        logic [63:0]  cnt;
        int           nb, ne, pl, k, l, i;
        next_sf = sf;
        if (special == 1) begin
            for (i = 0; i < 8; i++) c[32*i +: 32] = $urandom;
            codes.push_back(c);
            lens.push_back(256);
        end else if (special == 2) begin
            // two disjoint 256-deep paths need more nodes than exist
            codes.push_back('0);
            lens.push_back(256);
            c = '0;
            c[255] = 1'b1;
            codes.push_back(c);
            lens.push_back(256);
        end else begin
            codes.push_back('0);
            lens.push_back(1);
            codes.push_back(256'd1);
            lens.push_back(1);
            while (codes.size() < nleaf) begin
                i = $urandom_range(0, codes.size() - 1);
                if (lens[i] < 10) begin
                    c = codes[i];
                    l = lens[i];
                    codes[i] = c << 1;
                    lens[i]  = l + 1;
                    codes.push_back((c << 1) | 256'd1);
                    lens.push_back(l + 1);
                end
            end
        end
        // long codes keep the body short
        nb = (special == 1 || special == 2) ? 2 : $urandom_range(3, 20);
        case (cnt_mode)
            0: cnt = nb;
            1: cnt = 0;
            2: cnt = $urandom_range(1, nb);
            default: cnt = '1;
        endcase
        for (i = 0; i < 8; i++) push_byte(cnt[8*i +: 8]);
        ne = (special == 3) ? 256 : codes.size() - drop;
        push_byte(ne[7:0]);
        pl = pw_ok ? ((pw_len > MAX_PASSWORD_BYTES) ? MAX_PASSWORD_BYTES : pw_len)
                   : $urandom_range(0, 9);
        push_byte(pl[7:0]);
        for (i = 0; i < pl; i++)
            push_byte(pw_ok ? pw_word[8*i +: 8] : 8'($urandom));
        bit_cnt = 0;
        for (int e = 0; e < ne; e++) begin
            k = (special == 3) ? e % 2 : e + drop;
            l = lens[k];
            put_bits8(8'($urandom));
            put_bits8(l[7:0]);
            for (i = l - 1; i >= 0; i--) put_bit(codes[k][i]);
        end
        // a dropped entry leaves a hole that the body may hit
        for (int s = 0; s < nb; s++) begin
            k = $urandom_range(0, codes.size() - 1);
            for (i = lens[k] - 1; i >= 0; i--) put_bit(codes[k][i]);
        end
        while (bit_cnt != 0) put_bit($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) push_byte(8'($urandom));
    endtask

    task automatic random_file(input int special);
        // only a plain tree has a spare entry to leave out
        build_file(1'b1, special, $urandom_range(2, 12),
                   (special == 0) && ($urandom_range(0, 5) == 0),
                   $urandom_range(0, 9) < 8, ($urandom_range(0, 9) < 7) ? 0 :
                   $urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0) begin
            // stray bytes, now and then a restart among them
            for (int i = 0; i < 4; i++)
                byte_queue.push_back('{$urandom_range(0, 7) == 0, 8'($urandom)});
        end
    endtask

    // both password registers; valid stays up across the two transfers
    task automatic set_password(input logic [63:0] w, input logic [63:0] len);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_PWD_WORD;
        cfg_ch.data  <= w;
        do @(posedge i_clk); while (!cfg_ch.ready);
        pw_word = w;
        cfg_ch.index <= CFG_PWD_LEN;
        cfg_ch.data  <= len;
        do @(posedge i_clk); while (!cfg_ch.ready);
        pw_len = len[3:0];
        cfg_ch.valid <= 1'b0;
    endtask

    // idle once all bytes went in and all results came out; the tail covers
    // a byte still walking with nothing to report, or a clearing pass
    task automatic drain();
        do @(posedge i_clk);
        while (byte_queue.size() != 0 || byte_ch.valid || expected_res.size() != 0);
        repeat (600) @(posedge i_clk);
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial begin
        int target;
        i_rst_n            = 0;
        byte_ch.valid      = 0;
        byte_ch.start_file = 0;
        byte_ch.data_byte  = '0;
        cfg_ch.valid       = 0;
        cfg_ch.index       = CFG_PWD_WORD;
        cfg_ch.data        = '0;
        pw_word            = '0;
        pw_len             = '0;
        clear_parse();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: a one-leaf file without a restart flag, then a random password,
        // wrong unless its length is zero, followed by bytes the decoder must ignore
        build_file(1'b0, 0, 2, 1'b1, 1'b1, 0);
        build_file(1'b1, 0, 2, 1'b0, 1'b0, 0);
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_password({$urandom, $urandom}, 3);
                1: set_password('1, 8);
                2: set_password({$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF);
                default: set_password('0, 0);
            endcase
            if (p == 1) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 26;
                rx_idle_pct = 26;
            end
            if (p == 2) hold_req <= 1;
            if (p == 1 || p == 2) random_file(p);
            target = byte_queue.size() + 20;
            while (byte_queue.size() < target) random_file(0);
            drain();
        end

        repeat (100) @(posedge i_clk);
        $display("%0d bytes in, %0d symbols (%0d file ends), %0d error results,",
                 bytes_fed, n_symbols, n_eof, n_faults);
        $display("four password settings, node overflow and a 256-bit code");
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/hsd_pkg.sv
rtl/hsd_if.sv
rtl/hsd_ctrl.sv
rtl/hsd_dp.sv
rtl/huffman_stream_decoder.sv
bench/tb_top.sv
